[rtl/core/keyboard_power_up_handshake_assert.svh]
// Assertion macros for the keyboard power-up handshake block
`ifndef KEYBOARD_POWER_UP_HANDSHAKE_ASSERT_SVH
`define KEYBOARD_POWER_UP_HANDSHAKE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define KBPH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define KBPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/kbph_pkg.sv]
// Types and constants shared by the keyboard power-up handshake modules
package kbph_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned CountW = 5;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [PhaseW-1:0] PH_START   = 3'd0;
  localparam logic [PhaseW-1:0] PH_OFF     = 3'd1;
  localparam logic [PhaseW-1:0] PH_ON      = 3'd2;
  localparam logic [PhaseW-1:0] PH_DCD     = 3'd3;
  localparam logic [PhaseW-1:0] PH_RTS_LOW = 3'd4;
  localparam logic [PhaseW-1:0] PH_RTS_HI  = 3'd5;
  localparam logic [PhaseW-1:0] PH_READY   = 3'd6;
  localparam logic [PhaseW-1:0] PH_UNUSED  = 3'd7;

  localparam logic [2:0] REG_FIRST_OFF = 3'd0;
  localparam logic [2:0] REG_LATER_OFF = 3'd1;
  localparam logic [2:0] REG_DCD_SETTLE = 3'd2;
  localparam logic [2:0] REG_RTS_HOLD  = 3'd3;
  localparam logic [2:0] REG_RTS_PULSE = 3'd4;
  localparam logic [2:0] REG_ID_FIRST  = 3'd5;
  localparam logic [2:0] REG_ID_SECOND = 3'd6;
  localparam logic [2:0] REG_ID_LIMIT  = 3'd7;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] phase_since_ms;
    logic        dcd_level;
    logic        rts_level;
    logic        byte_valid;
    logic [7:0]  rx_byte;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              power_on;
    logic              rts_driven;
    logic              rts_high;
    logic              phase_changed;
    logic              ready_res;
  } out_item_t;

  typedef struct packed {
    logic [15:0]       first_off_delay_ms;
    logic [15:0]       later_off_delay_ms;
    logic [15:0]       dcd_settle_ms;
    logic [15:0]       rts_low_hold_ms;
    logic [15:0]       rts_pulse_ms;
    logic [7:0]        id_first_byte;
    logic [7:0]        id_second_byte;
    logic [CountW-1:0] id_byte_limit;
  } cfg_t;

endpackage

[rtl/core/keyboard_power_up_handshake.sv]
// Top level of the keyboard power-up handshake sequencer
//
// Each input item is one poll: current time, phase start time, DCD and RTS
// levels, an optional received byte and a restart request. Each poll gives
// exactly one result item: phase, supply enable, RTS drive and level, a
// phase-changed flag and the ready flag.
// The poll is captured in an input register; the phase update runs between
// that register and the result register, so each item passes the input
// register, then the result register. One item is taken per cycle while the
// output side does not stall.
// When the receiver stalls, the result register holds and the poll waiting
// in the input register holds with it; in_stall_o rises only while both are
// full and the receiver stalls. Configuration goes through the APB-style
// port, zero wait states.
// Reset puts the phase at start, marks the first boot, clears the byte
// count and ID bytes, turns the supply off, floats RTS low and loads the
// default delays and ID bytes.
module keyboard_power_up_handshake import kbph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;
  out_item_t result;
  logic      advance;
  logic      in_take;

  assign advance     = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~advance;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  kbph_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kbph_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (in_q),
    .step_i   (advance),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

`include "keyboard_power_up_handshake_assert.svh"

  `KBPH_ASSERT_NEXT(a_restart_to_start, advance && in_q.restart,
    out_valid_o && out_item_o.phase == PH_START && !out_item_o.power_on &&
    !out_item_o.rts_driven, "restart poll did not return to start")
  `KBPH_ASSERT_IMPL(a_stall_only_when_blocked, in_stall_o,
    out_valid_o && out_stall_i, "input stalled while output could move")
  `KBPH_ASSERT_IMPL(a_no_unused_phase, out_valid_o,
    out_item_o.phase != PH_UNUSED, "result carries the unused phase code")
  `KBPH_ASSERT_IMPL(a_rts_high_driven, out_valid_o && out_item_o.rts_high,
    out_item_o.rts_driven, "RTS high reported while floating")

endmodule

[rtl/core/kbph_cfg.sv]
// Configuration register file with an APB-style access port
module kbph_cfg import kbph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FIRST_OFF:  cfg_d.first_off_delay_ms = pwdata[15:0];
        REG_LATER_OFF:  cfg_d.later_off_delay_ms = pwdata[15:0];
        REG_DCD_SETTLE: cfg_d.dcd_settle_ms      = pwdata[15:0];
        REG_RTS_HOLD:   cfg_d.rts_low_hold_ms    = pwdata[15:0];
        REG_RTS_PULSE:  cfg_d.rts_pulse_ms       = pwdata[15:0];
        REG_ID_FIRST:   cfg_d.id_first_byte      = pwdata[7:0];
        REG_ID_SECOND:  cfg_d.id_second_byte     = pwdata[7:0];
        REG_ID_LIMIT:   cfg_d.id_byte_limit      = pwdata[CountW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIRST_OFF:  prdata = {16'd0, cfg_q.first_off_delay_ms};
      REG_LATER_OFF:  prdata = {16'd0, cfg_q.later_off_delay_ms};
      REG_DCD_SETTLE: prdata = {16'd0, cfg_q.dcd_settle_ms};
      REG_RTS_HOLD:   prdata = {16'd0, cfg_q.rts_low_hold_ms};
      REG_RTS_PULSE:  prdata = {16'd0, cfg_q.rts_pulse_ms};
      REG_ID_FIRST:   prdata = {24'd0, cfg_q.id_first_byte};
      REG_ID_SECOND:  prdata = {24'd0, cfg_q.id_second_byte};
      REG_ID_LIMIT:   prdata = {{(DataW-CountW){1'b0}}, cfg_q.id_byte_limit};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_off_delay_ms <= 16'd1000;
      cfg_q.later_off_delay_ms <= 16'd100;
      cfg_q.dcd_settle_ms      <= 16'd10;
      cfg_q.rts_low_hold_ms    <= 16'd200;
      cfg_q.rts_pulse_ms       <= 16'd10;
      cfg_q.id_first_byte      <= 8'd250;
      cfg_q.id_second_byte     <= 8'd253;
      cfg_q.id_byte_limit      <= 5'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/core/kbph_step.sv]
// Phase sequencer state and per-poll update logic
module kbph_step import kbph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  item_i,
  input  logic      step_i,
  output out_item_t result_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic              first_boot_q, first_boot_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        older_q, older_d;
  logic [7:0]        newer_q, newer_d;
  logic              power_q, power_d;
  logic              drive_q, drive_d;
  logic              level_q, level_d;

  logic [31:0]       elapsed;
  logic [15:0]       delay;
  logic              timed_out;
  logic [CountW-1:0] count_base;

  assign elapsed    = item_i.now_ms - item_i.phase_since_ms;
  assign timed_out  = elapsed > {16'd0, delay};
  assign count_base = (count_q >= cfg_i.id_byte_limit) ? '0 : count_q;

  always_comb begin
    unique case (phase_q)
      PH_OFF:     delay = first_boot_q ? cfg_i.first_off_delay_ms
                                       : cfg_i.later_off_delay_ms;
      PH_ON:      delay = cfg_i.dcd_settle_ms;
      PH_DCD:     delay = cfg_i.rts_low_hold_ms;
      PH_RTS_LOW: delay = cfg_i.rts_pulse_ms;
      default:    delay = '0;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    first_boot_d = first_boot_q;
    count_d      = count_q;
    older_d      = older_q;
    newer_d      = newer_q;
    power_d      = power_q;
    drive_d      = drive_q;
    level_d      = level_q;
    if (item_i.restart) begin
      phase_d = PH_START;
      power_d = 1'b0;
      drive_d = 1'b0;
      level_d = 1'b0;
      count_d = '0;
    end else begin
      unique case (phase_q)
        PH_START: begin
          power_d = 1'b0;
          drive_d = 1'b0;
          level_d = 1'b0;
          count_d = '0;
          phase_d = PH_OFF;
        end
        PH_OFF: begin
          if (timed_out) begin
            power_d = 1'b1;
            phase_d = PH_ON;
          end
        end
        PH_ON: begin
          if (timed_out && item_i.dcd_level) begin
            drive_d = 1'b1;
            level_d = 1'b0;
            phase_d = item_i.rts_level ? PH_DCD : PH_RTS_LOW;
          end
        end
        PH_DCD: begin
          if (timed_out) begin
            phase_d = PH_RTS_LOW;
          end
        end
        PH_RTS_LOW: begin
          if (timed_out) begin
            drive_d = 1'b1;
            level_d = 1'b1;
            phase_d = PH_RTS_HI;
          end
        end
        PH_RTS_HI: begin
          count_d = count_base;
          if (item_i.byte_valid) begin
            older_d = newer_q;
            newer_d = item_i.rx_byte;
            count_d = count_base + CountW'(1);
          end
          if (count_d >= 5'd2 && older_d == cfg_i.id_first_byte &&
              newer_d == cfg_i.id_second_byte) begin
            first_boot_d = 1'b0;
            count_d      = '0;
            phase_d      = PH_READY;
          end
        end
        PH_READY: phase_d = phase_q;
        default:  phase_d = PH_START;
      endcase
    end
  end

  assign result_o.phase         = phase_d;
  assign result_o.power_on      = power_d;
  assign result_o.rts_driven    = drive_d;
  assign result_o.rts_high      = drive_d & level_d;
  assign result_o.phase_changed = phase_d != phase_q;
  assign result_o.ready_res     = phase_d == PH_READY;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      first_boot_q <= 1'b1;
      count_q      <= '0;
      older_q      <= '0;
      newer_q      <= '0;
      power_q      <= 1'b0;
      drive_q      <= 1'b0;
      level_q      <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      first_boot_q <= first_boot_d;
      count_q      <= count_d;
      older_q      <= older_d;
      newer_q      <= newer_d;
      power_q      <= power_d;
      drive_q      <= drive_d;
      level_q      <= level_d;
    end
  end

endmodule

[sim/keyboard_power_up_handshake_test.sv]
// Self-checking testbench for the keyboard power-up handshake sequencer
`timescale 1ns / 1ps

module keyboard_power_up_handshake_test;
  import kbph_pkg::*;

  typedef enum logic [1:0] {
    IDLE_SENDER_LIGHT,
    IDLE_SENDER_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned SegmentItems = 113;
  localparam int unsigned MaxReports = 10;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_item_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  keyboard_power_up_handshake u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sequencer shadow state and register copy
  cfg_t              shadow_cfg;
  logic [PhaseW-1:0] seq_phase;
  logic              seq_first_boot;
  logic [CountW-1:0] id_count;
  logic [7:0]        id_older;
  logic [7:0]        id_newer;
  logic              supply_on;
  logic              rts_drive_q;
  logic              rts_level_q;

  out_item_t expected_results[$];
  int        send_idle_pct;
  int        out_stall_pct;
  int        fail_count = 0;
  int        quiet_cycles = 0;

  function automatic void drop_supply();
    supply_on   = 1'b0;
    rts_drive_q = 1'b0;
    rts_level_q = 1'b0;
    id_count    = '0;
  endfunction

  function automatic out_item_t advance_sequencer(input in_item_t p);
    logic [31:0]       elapsed;
    logic [31:0]       off_wait;
    logic [PhaseW-1:0] prev;
    logic [PhaseW-1:0] nxt;
    out_item_t         r;
    elapsed = p.now_ms - p.phase_since_ms;
    prev = seq_phase;
    nxt = prev;
    if (p.restart) begin
      nxt = PH_START;
      drop_supply();
    end else begin
      case (prev)
        PH_START: begin
          drop_supply();
          nxt = PH_OFF;
        end
        PH_OFF: begin
          off_wait = seq_first_boot ? {16'h0, shadow_cfg.first_off_delay_ms}
                                    : {16'h0, shadow_cfg.later_off_delay_ms};
          if (elapsed > off_wait) begin
            supply_on = 1'b1;
            nxt = PH_ON;
          end
        end
        PH_ON: begin
          if (elapsed > {16'h0, shadow_cfg.dcd_settle_ms} && p.dcd_level) begin
            rts_drive_q = 1'b1;
            rts_level_q = 1'b0;
            nxt = p.rts_level ? PH_DCD : PH_RTS_LOW;
          end
        end
        PH_DCD: begin
          if (elapsed > {16'h0, shadow_cfg.rts_low_hold_ms}) nxt = PH_RTS_LOW;
        end
        PH_RTS_LOW: begin
          if (elapsed > {16'h0, shadow_cfg.rts_pulse_ms}) begin
            rts_drive_q = 1'b1;
            rts_level_q = 1'b1;
            nxt = PH_RTS_HI;
          end
        end
        PH_RTS_HI: begin
          if (id_count >= shadow_cfg.id_byte_limit) id_count = '0;
          if (p.byte_valid) begin
            id_older = id_newer;
            id_newer = p.rx_byte;
            id_count = id_count + 5'd1;
          end
          if (id_count >= 2 && id_older == shadow_cfg.id_first_byte &&
              id_newer == shadow_cfg.id_second_byte) begin
            seq_first_boot = 1'b0;
            id_count = '0;
            nxt = PH_READY;
          end
        end
        PH_READY: begin
        end
        default: nxt = PH_START;
      endcase
    end
    seq_phase = nxt;
    r.phase = nxt;
    r.power_on = supply_on;
    r.rts_driven = rts_drive_q;
    r.rts_high = rts_drive_q & rts_level_q;
    r.phase_changed = (nxt != prev);
    r.ready_res = (nxt == PH_READY);
    return r;
  endfunction

  function automatic in_item_t make_poll(input logic [31:0] now, input logic [31:0] since,
                                         input logic dcd, input logic rts,
                                         input logic bval, input logic [7:0] rx,
                                         input logic rst);
    in_item_t p;
    p.now_ms = now;
    p.phase_since_ms = since;
    p.dcd_level = dcd;
    p.rts_level = rts;
    p.byte_valid = bval;
    p.rx_byte = rx;
    p.restart = rst;
    return p;
  endfunction

  // Aim the elapsed time at the wait of the current phase
  function automatic in_item_t random_poll();
    in_item_t    p;
    logic [31:0] thr;
    logic [31:0] elapsed;
    p.phase_since_ms = $urandom();
    p.dcd_level = ($urandom_range(0, 9) < 8);
    p.rts_level = 1'($urandom_range(0, 1));
    p.byte_valid = ($urandom_range(0, 9) < 3);
    p.rx_byte = 8'($urandom_range(0, 255));
    p.restart = ($urandom_range(0, 49) == 0);
    case (seq_phase)
      PH_OFF: thr = seq_first_boot ? {16'h0, shadow_cfg.first_off_delay_ms}
                                   : {16'h0, shadow_cfg.later_off_delay_ms};
      PH_ON: thr = {16'h0, shadow_cfg.dcd_settle_ms};
      PH_DCD: thr = {16'h0, shadow_cfg.rts_low_hold_ms};
      PH_RTS_LOW: thr = {16'h0, shadow_cfg.rts_pulse_ms};
      PH_RTS_HI: begin
        thr = $urandom();
        p.byte_valid = ($urandom_range(0, 9) < 8);
        case ($urandom_range(0, 2))
          0: p.rx_byte = shadow_cfg.id_first_byte;
          1: p.rx_byte = shadow_cfg.id_second_byte;
          default: p.rx_byte = 8'($urandom_range(0, 255));
        endcase
      end
      PH_READY: begin
        thr = $urandom();
        p.restart = ($urandom_range(0, 3) == 0);
      end
      default: thr = $urandom();
    endcase
    case ($urandom_range(0, 5))
      0: elapsed = thr - 1;
      1: elapsed = thr;
      2, 3: elapsed = thr + 1;
      4: elapsed = thr + $urandom_range(2, 100);
      default: elapsed = $urandom();
    endcase
    p.now_ms = p.phase_since_ms + elapsed;
    if ($urandom_range(0, 9) == 0) begin
      p = in_item_t'({$urandom(), $urandom(), 12'($urandom_range(0, 4095))});
    end
    return p;
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        send_idle_pct = 16;
        out_stall_pct = 46;
      end
      IDLE_SENDER_HEAVY: begin
        send_idle_pct = 46;
        out_stall_pct = 16;
      end
      default: begin
        send_idle_pct = 0;
        out_stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_poll(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(advance_sequencer(item));
  endtask

  // Drop valid and wait until every result is back and the pipeline is empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] word);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FIRST_OFF: shadow_cfg.first_off_delay_ms = word[15:0];
      REG_LATER_OFF: shadow_cfg.later_off_delay_ms = word[15:0];
      REG_DCD_SETTLE: shadow_cfg.dcd_settle_ms = word[15:0];
      REG_RTS_HOLD: shadow_cfg.rts_low_hold_ms = word[15:0];
      REG_RTS_PULSE: shadow_cfg.rts_pulse_ms = word[15:0];
      REG_ID_FIRST: shadow_cfg.id_first_byte = word[7:0];
      REG_ID_SECOND: shadow_cfg.id_second_byte = word[7:0];
      default: shadow_cfg.id_byte_limit = word[CountW-1:0];
    endcase
  endtask

  // Load every register; upper bits carry junk that the block must drop
  task automatic load_config(input logic [15:0] first_off, input logic [15:0] later_off,
                             input logic [15:0] settle, input logic [15:0] hold,
                             input logic [15:0] pulse, input logic [7:0] id_first,
                             input logic [7:0] id_second, input logic [4:0] limit);
    write_reg(REG_FIRST_OFF, {16'($urandom()), first_off});
    write_reg(REG_LATER_OFF, {16'($urandom()), later_off});
    write_reg(REG_DCD_SETTLE, {16'($urandom()), settle});
    write_reg(REG_RTS_HOLD, {16'($urandom()), hold});
    write_reg(REG_RTS_PULSE, {16'($urandom()), pulse});
    write_reg(REG_ID_FIRST, {24'($urandom()), id_first});
    write_reg(REG_ID_SECOND, {24'($urandom()), id_second});
    write_reg(REG_ID_LIMIT, {27'($urandom()), limit});
  endtask

  task automatic test_first_boot();
    send_poll(make_poll(32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd1000, 32'd0, 1'b1, 1'b1, 1'b1, 8'd250, 1'b0));
    send_poll(make_poll(32'd1001, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd10, 32'd0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd11, 32'd0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd11, 32'd0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd200, 32'd0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd201, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd10, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd11, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd250, 1'b0));
    send_poll(make_poll(32'd0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd253, 1'b0));
    send_poll(make_poll(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0));
  endtask

  task automatic test_restart_later_boot();
    send_poll(make_poll(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1));
    send_poll(make_poll(32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1));
    send_poll(make_poll(32'd0, 32'd0, 1'b0, 1'b0, 1'b1, 8'h5A, 1'b0));
    send_poll(make_poll(32'h0000_0050, 32'hFFFF_FFEC, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0));
  endtask

  task automatic test_byte_limit_below_two();
    drain();
    write_reg(REG_ID_LIMIT, {27'($urandom()), 5'd1});
    send_poll(make_poll(32'd11, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
    send_poll(make_poll(32'd0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd250, 1'b0));
    send_poll(make_poll(32'd0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd253, 1'b0));
    send_poll(make_poll(32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1));
  endtask

  task automatic test_random_polls();
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      set_idling(seg < 2 ? IDLE_SENDER_LIGHT : seg < 4 ? IDLE_SENDER_HEAVY : IDLE_NONE);
      case (seg)
        0: load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'($urandom()),
                       8'($urandom()), 5'd2);
        1: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                       8'hFF, 5'd31);
        2: load_config(16'($urandom()), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()), 8'($urandom()),
                       8'($urandom()), 5'd0);
        3: load_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 300)), 8'($urandom()), 8'($urandom()),
                       5'($urandom_range(2, 20)));
        4: load_config(16'd1000, 16'd100, 16'd10, 16'd200, 16'd10, 8'd250, 8'd253,
                       5'd20);
        default: load_config(16'($urandom()), 16'($urandom()), 16'($urandom()),
                             16'($urandom()), 16'($urandom()), 8'h00, 8'h00, 5'd1);
      endcase
      for (int n = 0; n < SegmentItems; n++) send_poll(random_poll());
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("unexpected result item: phase=%0d", out_item_o.phase);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.phase !== want.phase || out_item_o.power_on !== want.power_on ||
            out_item_o.rts_driven !== want.rts_driven ||
            out_item_o.rts_high !== want.rts_high ||
            out_item_o.phase_changed !== want.phase_changed ||
            out_item_o.ready_res !== want.ready_res) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("mismatch: expected phase=%0d pwr=%b drv=%b hi=%b chg=%b rdy=%b",
                     want.phase, want.power_on, want.rts_driven, want.rts_high,
                     want.phase_changed, want.ready_res);
            $display("          got      phase=%0d pwr=%b drv=%b hi=%b chg=%b rdy=%b",
                     out_item_o.phase, out_item_o.power_on, out_item_o.rts_driven,
                     out_item_o.rts_high, out_item_o.phase_changed, out_item_o.ready_res);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("keyboard_power_up_handshake_test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    shadow_cfg = '{16'd1000, 16'd100, 16'd10, 16'd200, 16'd10, 8'd250, 8'd253, 5'd10};
    seq_phase = PH_START;
    seq_first_boot = 1'b1;
    id_count = '0;
    id_older = '0;
    id_newer = '0;
    drop_supply();
    set_idling(IDLE_SENDER_LIGHT);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_boot();
    test_restart_later_boot();
    test_byte_limit_below_two();
    test_random_polls();
    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("keyboard_power_up_handshake_test passed");
    end else begin
      $display("keyboard_power_up_handshake_test failed");
    end
    $finish;
  end

endmodule
